[sv/lsav_pkg.sv]
// shared types, constants and saturation helpers for the limit surface quadrature block
// no dependencies

package lsav_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int MUL_W = 65;
	localparam int PROD_W = 128;
	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic [62:0] AREA_MAX = '1;
	// reciprocal of six scaled by 2^66, rounded up: exact floor for any 64-bit value
	localparam logic [63:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_CROSS_A,
		ST_CROSS_B,
		ST_SQ,
		ST_DOT,
		ST_SQRT,
		ST_AREA,
		ST_VOL,
		ST_DIV,
		ST_CLOSE,
		ST_EMIT
	} lsav_state_t;

	// clamp a signed 128-bit value to the signed 64-bit range
	function automatic logic signed [63:0] sat128(input logic signed [127:0] v);
		if (v[127:63] == '0 || v[127:63] == '1) begin
			return v[63:0];
		end
		return v[127] ? S64_MIN : S64_MAX;
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? S64_MIN : S64_MAX;
		end
		return s[63:0];
	endfunction

endpackage

[sv/lsav_mul.sv]
// shared shift-add multiplier, 65 x 65 signed, one partial product per cycle
// depends on lsav_pkg

module lsav_mul (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [lsav_pkg::MUL_W-1:0]  a,
	input  logic signed [lsav_pkg::MUL_W-1:0]  b,
	output logic                               done,
	output logic signed [lsav_pkg::PROD_W-1:0] prod
);
	import lsav_pkg::*;

	localparam int CNT_W = $clog2(MUL_W);

	logic              run_q, fin_q, done_q, neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MUL_W-1:0]  mcand_q;
	logic [2*MUL_W:0]  acc_q;
	logic [PROD_W-1:0] prod_q;
	logic [MUL_W-1:0]  mag_a, mag_b;
	logic [MUL_W+1:0]  upper;

	assign mag_a = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
	assign mag_b = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
	assign upper = {1'b0, acc_q[2*MUL_W:MUL_W]} + (acc_q[0] ? {2'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mag_a;
			acc_q   <= {{(MUL_W+1){1'b0}}, mag_b};
			neg_q   <= a[MUL_W-1] ^ b[MUL_W-1];
		end else if (run_q) begin
			acc_q <= {upper, acc_q[MUL_W-1:1]};
		end
		if (fin_q) begin
			prod_q <= neg_q ? -acc_q[PROD_W-1:0] : acc_q[PROD_W-1:0];
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

[sv/lsav_sqrt.sv]
// restoring integer square root of a 128-bit value, one root bit per cycle
// depends on lsav_pkg

module lsav_sqrt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] radicand,
	output logic         done,
	output logic [63:0]  root
);
	import lsav_pkg::*;

	logic         run_q, done_q;
	logic [5:0]   cnt_q;
	logic [65:0]  rem_q;
	logic [63:0]  root_q;
	logic [127:0] n_q;
	logic [67:0]  r, t;
	logic         ge;

	assign r  = {rem_q, n_q[127:126]};
	assign t  = {2'b0, root_q, 2'b01};
	assign ge = r >= t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			n_q    <= radicand;
		end else if (run_q) begin
			rem_q  <= ge ? 66'(r - t) : r[65:0];
			root_q <= {root_q[62:0], ge};
			n_q    <= {n_q[125:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

[sv/limit_surface_area_volume_quadrature.sv]
// top level: limit surface area and volume quadrature for one regular face
// depends on lsav_pkg, lsav_mul, lsav_sqrt
//
// usage
//  input stream: one request per control point per quadrature sample
//   s_tdata holds the coordinates, the three shape values and the weight,
//   s_tuser[0] marks the last point of a sample, s_tlast the last of a face
//  output stream: one request per face, m_tdata = {volume, area}
//  every product goes through one shared shift-add multiplier
//  a request without a sample or face end takes 9 products; the next request is
//   taken only once the sequencer is back in idle
//  a sample or face end adds 15 products (the divide by six is a reciprocal multiply),
//   a square root and a closing state; s_tready is low meanwhile
//  a face end adds the emit state to load the output register; if the
//   previous result still waits the sequencer holds until m_tready takes it
//  reset clears all accumulators, the sequencer and the output valid

module limit_surface_area_volume_quadrature #(
	parameter int COORD_WIDTH = lsav_pkg::COORD_WIDTH_DEF,
	localparam int S_W = ((3 * COORD_WIDTH + 128 + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	// vertex_x, vertex_y, vertex_z, shape_value, shape_du, shape_dv, weight
	input  logic [S_W-1:0] s_tdata,
	// last_of_sample
	input  logic [0:0]     s_tuser,
	// last_of_face
	input  logic           s_tlast,
	output logic           m_tvalid,
	input  logic           m_tready,
	// face_area (63 bits), face_volume (64 bits), one zero pad bit
	output logic [127:0]   m_tdata
);
	import lsav_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int SB = 3 * CW;

	lsav_state_t state_q, state_d;

	// latched request
	logic signed [CW-1:0] coord_q [3];
	logic signed [31:0]   shape_q [3];
	logic [31:0]          weight_q;
	logic                 last_sample_q, last_face_q;

	// vectors: row 0 position, row 1 tangent u, row 2 tangent v
	logic signed [63:0]   vec_q [3][3];
	logic signed [63:0]   cross_q [3];
	logic signed [95:0]   tmp_q;
	logic [127:0]         sum_q;
	logic signed [127:0]  dsum_q;
	logic [63:0]          norm_q;
	logic [62:0]          area_q;
	logic signed [63:0]   vol_q;
	logic [63:0]          dq_q;
	logic                 tneg_q;
	logic [1:0]           axis_q, kind_q;
	logic                 issued_q;
	logic                 out_valid_q;
	logic [127:0]         out_q;

	// shared multiplier hookup
	logic                        mul_start, mul_done;
	logic signed [MUL_W-1:0]     mul_a, mul_b;
	logic signed [PROD_W-1:0]    prod;
	logic                        sqrt_start, sqrt_done;
	logic [63:0]                 sqrt_root;

	logic [1:0]          ax_j, ax_k;
	logic signed [63:0]  dot, term, vstep, quot;
	logic [63:0]         add_sum, tmag;
	logic [62:0]         area_add;
	logic                accept, emit_go, is_mul;

	lsav_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
	);

	lsav_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start),
		.radicand(sum_q), .done(sqrt_done), .root(sqrt_root)
	);

	// cyclic neighbors of the current axis
	always_comb begin
		case (axis_q)
			2'd0: begin ax_j = 2'd1; ax_k = 2'd2; end
			2'd1: begin ax_j = 2'd2; ax_k = 2'd0; end
			default: begin ax_j = 2'd0; ax_k = 2'd1; end
		endcase
	end

	assign dot = sat128(dsum_q);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_ACC: begin
				mul_a = MUL_W'(coord_q[axis_q]);
				mul_b = MUL_W'(shape_q[kind_q]);
			end
			ST_CROSS_A: begin
				mul_a = MUL_W'(vec_q[1][ax_j]);
				mul_b = MUL_W'(vec_q[2][ax_k]);
			end
			ST_CROSS_B: begin
				mul_a = MUL_W'(vec_q[1][ax_k]);
				mul_b = MUL_W'(vec_q[2][ax_j]);
			end
			ST_SQ: begin
				mul_a = MUL_W'(cross_q[axis_q]);
				mul_b = MUL_W'(cross_q[axis_q]);
			end
			ST_DOT: begin
				mul_a = MUL_W'(vec_q[0][axis_q]);
				mul_b = MUL_W'(cross_q[axis_q]);
			end
			ST_AREA: begin
				mul_a = {1'b0, norm_q};
				mul_b = {33'b0, weight_q};
			end
			ST_VOL: begin
				mul_a = MUL_W'(dot);
				mul_b = {33'b0, weight_q};
			end
			// magnitude of the volume step times the scaled reciprocal of six
			ST_DIV: begin
				mul_a = {1'b0, dq_q};
				mul_b = {1'b0, RECIP6};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// per-product results
	assign term     = sat128(prod >>> 14);
	assign area_add = (|prod[127:95]) ? AREA_MAX : prod[94:32];
	assign add_sum  = {1'b0, area_q} + {1'b0, area_add};
	assign vstep    = sat128(prod >>> 31);
	assign tmag     = vstep[63] ? 64'(-vstep) : 64'(vstep);
	assign quot     = tneg_q ? -$signed(dq_q) : $signed(dq_q);

	assign accept  = s_tvalid && s_tready;
	assign emit_go = !out_valid_q || m_tready;
	assign is_mul  = (state_q == ST_ACC) || (state_q == ST_CROSS_A) ||
		(state_q == ST_CROSS_B) || (state_q == ST_SQ) || (state_q == ST_DOT) ||
		(state_q == ST_AREA) || (state_q == ST_VOL) || (state_q == ST_DIV);

	// sequencer
	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		mul_start  = is_mul && !issued_q;
		sqrt_start = (state_q == ST_SQRT) && !issued_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = ST_ACC;
			end
			ST_ACC: begin
				if (mul_done && axis_q == 2'd2 && kind_q == 2'd2) begin
					state_d = (last_sample_q || last_face_q) ? ST_CROSS_A : ST_IDLE;
				end
			end
			ST_CROSS_A: if (mul_done) state_d = ST_CROSS_B;
			ST_CROSS_B: if (mul_done) state_d = (axis_q == 2'd2) ? ST_SQ : ST_CROSS_A;
			ST_SQ:      if (mul_done) state_d = ST_DOT;
			ST_DOT:     if (mul_done) state_d = (axis_q == 2'd2) ? ST_SQRT : ST_SQ;
			ST_SQRT:    if (sqrt_done) state_d = ST_AREA;
			ST_AREA:    if (mul_done) state_d = ST_VOL;
			ST_VOL:     if (mul_done) state_d = ST_DIV;
			ST_DIV:     if (mul_done) state_d = ST_CLOSE;
			ST_CLOSE:   state_d = last_face_q ? ST_EMIT : ST_IDLE;
			ST_EMIT:    if (emit_go) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q    <= 1'b0;
			axis_q      <= '0;
			kind_q      <= '0;
			out_valid_q <= 1'b0;
			area_q      <= '0;
			vol_q       <= '0;
			sum_q       <= '0;
			dsum_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) vec_q[k][i] <= '0;
			end
		end else begin
			if (mul_done || sqrt_done) begin
				issued_q <= 1'b0;
			end else if (mul_start || sqrt_start) begin
				issued_q <= 1'b1;
			end
			if (state_q == ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					axis_q <= '0;
					kind_q <= '0;
				end
				ST_ACC: begin
					if (mul_done) begin
						vec_q[kind_q][axis_q] <= sat_add64(vec_q[kind_q][axis_q], term);
						if (axis_q == 2'd2) begin
							axis_q <= '0;
							kind_q <= (kind_q == 2'd2) ? 2'd0 : kind_q + 2'd1;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end
				end
				ST_CROSS_B: begin
					if (mul_done) axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
				end
				ST_SQ: begin
					if (mul_done) sum_q <= sum_q + prod;
				end
				ST_DOT: begin
					if (mul_done) begin
						dsum_q <= dsum_q + 128'(prod >>> 32);
						axis_q <= (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
					end
				end
				ST_AREA: begin
					if (mul_done) area_q <= add_sum[63] ? AREA_MAX : add_sum[62:0];
				end
				ST_CLOSE: begin
					// sample closed: fold in volume, clear the vectors
					vol_q  <= sat_add64(vol_q, quot);
					sum_q  <= '0;
					dsum_q <= '0;
					for (int k = 0; k < 3; k++) begin
						for (int i = 0; i < 3; i++) vec_q[k][i] <= '0;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						area_q <= '0;
						vol_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				coord_q[i] <= s_tdata[i*CW +: CW];
				shape_q[i] <= s_tdata[SB + 32*i +: 32];
			end
			weight_q      <= s_tdata[SB + 96 +: 32];
			last_sample_q <= s_tuser[0];
			last_face_q   <= s_tlast;
		end
		if (state_q == ST_CROSS_A && mul_done) tmp_q <= prod[127:32];
		if (state_q == ST_CROSS_B && mul_done) begin
			cross_q[axis_q] <= sat128(128'(tmp_q) - 128'(prod >>> 32));
		end
		if (sqrt_done) norm_q <= sqrt_root;
		if (state_q == ST_VOL && mul_done) begin
			dq_q   <= tmag;
			tneg_q <= vstep[63];
		end
		// quotient magnitude: high bits of the reciprocal product
		if (state_q == ST_DIV && mul_done) dq_q <= {2'b00, prod[127:66]};
		if (state_q == ST_EMIT && emit_go) out_q <= {1'b0, vol_q, area_q};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

[test/limit_surface_area_volume_quadrature_check.sv]
// checker for the limit surface quadrature block: watches both streams,
// predicts each face result and compares it field by field
// depends on lsav_pkg for the area limit

module limit_surface_area_volume_quadrature_check (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [223:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         s_tlast,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	output int           fails,
	output int           pending
);

	typedef struct {
		logic [62:0]        area;
		logic signed [63:0] volume;
	} face_sums_t;

	face_sums_t face_q[$];

	// running sums of the face under way
	logic signed [63:0] pos_sum[3];
	logic signed [63:0] du_sum[3];
	logic signed [63:0] dv_sum[3];
	logic [63:0]        area_sum;
	logic signed [63:0] volume_sum;

	function automatic logic signed [63:0] clamp64(input logic signed [127:0] v);
		if (v > 128'sh7FFF_FFFF_FFFF_FFFF) begin
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		if (v < -128'sh8000_0000_0000_0000) begin
			return 64'sh8000_0000_0000_0000;
		end
		return v[63:0];
	endfunction

	function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		wa = a;
		wb = b;
		return clamp64(wa + wb);
	endfunction

	// full-width product, floor shift
	function automatic logic signed [127:0] mul_floor(input logic signed [63:0] a,
		input logic signed [63:0] b, input int sh);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		wa = a;
		wb = b;
		return (wa * wb) >>> sh;
	endfunction

	function automatic logic [63:0] floor_root(input logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] sq;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			sq = {64'd0, c} * {64'd0, c};
			if (sq <= n) begin
				r = c;
			end
		end
		return r;
	endfunction

	task automatic close_sample(input logic [31:0] w);
		logic signed [63:0]  nrm[3];
		logic [127:0]        sq_sum;
		logic signed [127:0] dot_sum;
		logic [63:0]         mag;
		logic [63:0]         len;
		logic [127:0]        prod;
		logic [63:0]         step;
		logic signed [63:0]  dot;
		logic signed [63:0]  vstep;
		sq_sum = '0;
		dot_sum = '0;
		for (int i = 0; i < 3; i++) begin
			nrm[i] = clamp64(mul_floor(du_sum[(i + 1) % 3], dv_sum[(i + 2) % 3], 32)
				- mul_floor(du_sum[(i + 2) % 3], dv_sum[(i + 1) % 3], 32));
		end
		for (int i = 0; i < 3; i++) begin
			mag = nrm[i][63] ? 64'(-nrm[i]) : nrm[i];
			sq_sum += {64'd0, mag} * {64'd0, mag};
			dot_sum += mul_floor(pos_sum[i], nrm[i], 32);
		end
		len = floor_root(sq_sum);
		// the extra bit of the shift folds in the half
		prod = ({96'd0, w} * {64'd0, len}) >> 32;
		step = (prod[127:64] != 0) ? '1 : prod[63:0];
		if (step > lsav_pkg::AREA_MAX) begin
			step = lsav_pkg::AREA_MAX;
		end
		area_sum = (step > lsav_pkg::AREA_MAX - area_sum) ? lsav_pkg::AREA_MAX
			: area_sum + step;
		dot = clamp64(dot_sum);
		vstep = clamp64(mul_floor(dot, {32'd0, w}, 31));
		volume_sum = add_clamp(volume_sum, vstep / 64'sd6);
		for (int i = 0; i < 3; i++) begin
			pos_sum[i] = '0;
			du_sum[i] = '0;
			dv_sum[i] = '0;
		end
	endtask

	task automatic take_point(input logic [223:0] d, input logic ls, input logic lf);
		logic signed [63:0] crd;
		logic signed [63:0] sv;
		logic signed [63:0] su;
		logic signed [63:0] sd;
		face_sums_t         res;
		sv = $signed(d[127:96]);
		su = $signed(d[159:128]);
		sd = $signed(d[191:160]);
		for (int i = 0; i < 3; i++) begin
			crd = $signed(d[32 * i +: 32]);
			pos_sum[i] = add_clamp(pos_sum[i], clamp64(mul_floor(crd, sv, 14)));
			du_sum[i] = add_clamp(du_sum[i], clamp64(mul_floor(crd, su, 14)));
			dv_sum[i] = add_clamp(dv_sum[i], clamp64(mul_floor(crd, sd, 14)));
		end
		if (ls || lf) begin
			close_sample(d[223:192]);
		end
		if (lf) begin
			res.area = area_sum[62:0];
			res.volume = volume_sum;
			face_q.push_back(res);
			area_sum = '0;
			volume_sum = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		face_sums_t want;
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_sum[i] = '0;
				du_sum[i] = '0;
				dv_sum[i] = '0;
			end
			area_sum = '0;
			volume_sum = '0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (face_q.size() == 0) begin
					fails++;
					$display("%0t: face result with none expected: area %h volume %h",
						$time, m_tdata[62:0], m_tdata[126:63]);
				end else begin
					want = face_q.pop_front();
					if (m_tdata[62:0] !== want.area) begin
						fails++;
						$display("%0t: area expected %h actual %h", $time, want.area,
							m_tdata[62:0]);
					end
					if (m_tdata[126:63] !== want.volume) begin
						fails++;
						$display("%0t: volume expected %h actual %h", $time, want.volume,
							m_tdata[126:63]);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				take_point(s_tdata, s_tuser[0], s_tlast);
			end
			pending = face_q.size();
		end
	end

	initial begin
		fails = 0;
	end

endmodule

[test/limit_surface_area_volume_quadrature_test.sv]
// testbench top for the limit surface quadrature block: clock, reset,
// request stimulus and the verdict; depends on the checker module and the block

module limit_surface_area_volume_quadrature_test;

	localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam logic [31:0] W_ONE = 32'h8000_0000;
	localparam int HOLD_CYCLES = 20000;
	localparam int DRAIN_CYCLES = 3000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [223:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	int fails;
	int pending;
	int sent = 0;
	// handshake state latched mid-cycle, so it reflects what the next edge sees
	bit s_fire;
	bit quiet_send = 1'b0;
	bit hold_req = 1'b0;

	always #1 clk = ~clk;

	always @(negedge clk) begin
		s_fire = s_tvalid && s_tready;
	end

	limit_surface_area_volume_quadrature uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	limit_surface_area_volume_quadrature_check chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.fails(fails),
		.pending(pending)
	);

	// one request: coordinates, shape values, weight, sample and face marks
	task automatic send_point(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [31:0] sv, input logic [31:0] du,
		input logic [31:0] dv, input logic [31:0] w, input logic ls, input logic lf);
		int gap;
		if (!quiet_send && $urandom_range(99) < 36) begin
			gap = $urandom_range(4, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {w, dv, du, sv, z, y, x};
		s_tuser <= ls;
		s_tlast <= lf;
		do @(posedge clk); while (!s_fire);
		sent++;
	endtask

	// mix of full random, small, extreme and zero values
	function automatic logic [31:0] pick32();
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(2097152)) - 1048576);
			3: return $urandom_range(1) ? S32_MAX : S32_MIN;
			4: return 32'($signed($urandom_range(1 << 30)) - (1 << 29));
			default: return '0;
		endcase
	endfunction

	function automatic logic [31:0] pick_weight();
		case ($urandom_range(3))
			0: return $urandom;
			1: return W_ONE;
			2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom_range(32'h7FFF_FFFF);
		endcase
	endfunction

	// a face of one or more samples, mostly the full one-ring of twelve
	task automatic send_face(input int samples, input bit noisy);
		int n;
		logic [31:0] w;
		for (int s = 0; s < samples; s++) begin
			n = (noisy || $urandom_range(9) < 3) ? $urandom_range(14, 1) : 12;
			w = pick_weight();
			for (int p = 0; p < n; p++) begin
				// weights off the sample end are ignored, so they are random
				send_point(pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
					(p == n - 1) ? w : $urandom,
					(p == n - 1) ? (noisy ? 1'($urandom) : 1'b1) : (noisy && $urandom_range(7) == 0),
					(s == samples - 1) && (p == n - 1));
		end
		end
	endtask

	// receiver: random stalls, one quiet stretch, one long hold-off on request
	initial begin
		bit held;
		int cyc;
		held = 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_req && !held) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else begin
				m_tready <= (cyc > 200000 && cyc < 320000) || $urandom_range(99) >= 36;
			end
		end
	end

	initial begin
		#20000000;
		$display("limit_surface_area_volume_quadrature_test: FAIL");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// face end alone, without a sample mark, on an empty face
		send_point('0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
		// extremes everywhere, saturating tangents and sums, full-scale weight
		send_point(S32_MAX, '0, '0, S32_MAX, S32_MAX, '0, '0, 1'b0, 1'b0);
		send_point('0, S32_MAX, '0, S32_MIN, '0, S32_MAX, 32'h1234_5678, 1'b0, 1'b0);
		send_point('0, '0, S32_MIN, S32_MAX, S32_MIN, S32_MIN, 32'hFFFF_FFFF, 1'b1, 1'b0);
		// second sample ended by the face mark only
		send_point(S32_MIN, S32_MAX, '0, S32_MIN, S32_MIN, S32_MAX, '0, 1'b0, 1'b0);
		send_point(S32_MAX, S32_MIN, S32_MAX, S32_MAX, S32_MAX, S32_MIN, W_ONE, 1'b0, 1'b1);
		// modest values, unit weight, both marks on a one-point sample
		send_point(32'h0001_0000, '0, '0, 32'h4000_0000, 32'h4000_0000, '0, W_ONE,
			1'b0, 1'b0);
		send_point('0, 32'h0001_0000, '0, '0, '0, 32'h4000_0000, 32'h0, 1'b0, 1'b0);
		send_point('0, '0, 32'h0001_0000, 32'h4000_0000, '0, '0, W_ONE, 1'b1, 1'b0);
		send_point(32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 32'hC000_0000,
			32'h2000_0000, 32'hE000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1);
		// negative volume and zero weight on a closed sample
		send_point(32'hFFFF_0000, '0, '0, 32'h4000_0000, '0, 32'h4000_0000, '0, 1'b0, 1'b0);
		send_point('0, 32'hFFFF_0000, '0, 32'h4000_0000, 32'h4000_0000, '0, 32'h0,
			1'b1, 1'b0);
		send_point('0, '0, 32'h0001_0000, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
			W_ONE, 1'b1, 1'b1);
		s_tvalid <= 1'b0;

		// pause until every face result is back
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		// short faces while the receiver holds off, so the block backs up
		hold_req <= 1'b1;
		for (int f = 0; f < 8; f++) begin
			send_face(1, 1'b1);
		end

		while (sent < 636) begin
			quiet_send = (sent > 300 && sent < 400);
			if ($urandom_range(9) < 2) begin
				send_face($urandom_range(2, 1), 1'b1);
			end else begin
				send_face($urandom_range(2, 1), 1'b0);
			end
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("limit_surface_area_volume_quadrature_test: PASS");
		end else begin
			$display("limit_surface_area_volume_quadrature_test: FAIL");
		end
		$finish;
	end

endmodule
